// File: sv/scba_pkg.sv
// shared types, constants and class-count helpers for the size class block allocator
`timescale 1ns / 1ps

package scba_pkg;

    localparam int REQ_TYPE_W   = 2;
    localparam int REQ_SIZE_W   = 7;
    localparam int ADDRESS_W    = 10;
    localparam int STATUS_W     = 2;
    localparam int AVAIL_W      = 16;
    localparam int HDR_W        = 8;
    localparam int HEAP_LIMIT_W = 11;
    localparam int MAX_REQ_W    = 8;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 11;

    typedef logic [AVAIL_W-1:0] avail_t;
    typedef logic [HDR_W-1:0]   hdr_t;

    localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC   = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_FREE    = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_RECOUNT = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOSPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BADFREE = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_HEAP_LIMIT  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_REQUEST = 1'd1;

    localparam logic [HEAP_LIMIT_W-1:0] HEAP_LIMIT_RST  = 11'd1024;
    localparam logic [MAX_REQ_W-1:0]    MAX_REQUEST_RST = 8'd128;

    localparam avail_t AV_RECOUNT = 16'h8000;
    localparam avail_t AV_GT8     = 16'h6000;
    localparam avail_t AV_ODD     = 16'h1C00;
    localparam avail_t AV_EQ8     = 16'h0300;
    localparam avail_t AV_EQ4     = 16'h00C0;
    localparam avail_t AV_EQ2     = 16'h0038;
    localparam avail_t AV_EQ1     = 16'h0007;
    localparam avail_t AV_ONES    = 16'h2549;

    function automatic avail_t class_of(input hdr_t size);
        avail_t id;
        if (size == 8'd0)
            id = '0;
        else if (size == 8'd1)
            id = AV_EQ1;
        else if (size == 8'd2)
            id = AV_EQ2;
        else if (size == 8'd4)
            id = AV_EQ4;
        else if (size == 8'd8)
            id = AV_EQ8;
        else if (size < 8'd8)
            id = AV_ODD;
        else
            id = AV_GT8;
        return id;
    endfunction

    // bump the class field, set the recount flag instead when the field wraps
    function automatic avail_t count_freed(input avail_t counts, input hdr_t size);
        avail_t id;
        avail_t t;
        id = class_of(size);
        t  = counts + (id & AV_ONES);
        if ((counts & id) != '0 && (t & id) == '0)
            return counts | AV_RECOUNT;
        else
            return t;
    endfunction

endpackage

// File: sv/scba_ifs.sv
// request and response channel interfaces
`timescale 1ns / 1ps

interface scba_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [scba_pkg::REQ_TYPE_W-1:0]      req_type;
    logic [scba_pkg::REQ_SIZE_W-1:0]      req_size;
    logic [scba_pkg::ADDRESS_W-1:0]       address;

    modport source (output valid, output req_type, output req_size, output address,
                    input ready);
    modport sink   (input valid, input req_type, input req_size, input address,
                    output ready);
endinterface

interface scba_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [scba_pkg::STATUS_W-1:0]        status;
    logic [scba_pkg::ADDRESS_W-1:0]       alloc_address;
    logic [scba_pkg::AVAIL_W-1:0]         avail_word;

    modport source (output valid, output status, output alloc_address, output avail_word,
                    input ready);
    modport sink   (input valid, input status, input alloc_address, input avail_word,
                    output ready);
endinterface

// File: sv/size_class_block_allocator.sv
// size class block allocator top level: header ram, walk sequencer, class counts
// reject or idle recount: straight to result; free: read, check; bump alloc: bump state; a walk
//   reads, then checks each header visited, then a reuse hit or a recount goes to result, else bump;
//   one word in flight, the next request taken in idle after the result loads; a result still
//   held downstream stalls the sequencer; reset clears control state at once, then a clearing
//   pass zeroes every row of the header ram, taking no request word
`timescale 1ns / 1ps

module size_class_block_allocator #(
    parameter int HEAP_BYTES = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [scba_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [scba_pkg::CFG_DATA_W-1:0]     cfg_data,
    scba_req_if.sink                            req,
    scba_rsp_if.source                          rsp
);

    localparam int AW = $clog2(HEAP_BYTES);
    localparam int FW = AW + 8;
    localparam int LW = (AW + 1 > scba_pkg::HEAP_LIMIT_W) ? AW + 1 : scba_pkg::HEAP_LIMIT_W;
    localparam logic [LW-1:0] HEAP_LW  = LW'(HEAP_BYTES);
    localparam logic [AW-1:0] LAST_ROW = AW'(HEAP_BYTES - 1);

    typedef enum logic [7:0] {
        ST_CLEAR    = 8'b00000001,
        ST_IDLE     = 8'b00000010,
        ST_WALK_RD  = 8'b00000100,
        ST_WALK_CHK = 8'b00001000,
        ST_BUMP     = 8'b00010000,
        ST_FREE_RD  = 8'b00100000,
        ST_FREE_CHK = 8'b01000000,
        ST_RESULT   = 8'b10000000
    } state_t;

    state_t                                 state_reg, state_next;
    logic [AW-1:0]                          bump_reg, bump_next;
    scba_pkg::avail_t                       counts_reg, counts_next;
    logic [FW-1:0]                          walk_reg, walk_next;
    logic [AW-1:0]                          clr_reg, clr_next;
    logic [scba_pkg::REQ_TYPE_W-1:0]        type_reg, type_next;
    logic [scba_pkg::REQ_SIZE_W-1:0]        size_reg, size_next;
    logic [scba_pkg::ADDRESS_W-1:0]         addr_reg, addr_next;
    logic [scba_pkg::STATUS_W-1:0]          status_reg, status_next;
    logic [scba_pkg::ADDRESS_W-1:0]         where_reg, where_next;

    logic                                   out_valid_reg;
    logic [scba_pkg::STATUS_W-1:0]          out_status_reg;
    logic [scba_pkg::ADDRESS_W-1:0]         out_where_reg;
    scba_pkg::avail_t                       out_avail_reg;
    logic                                   out_load;

    logic [scba_pkg::HEAP_LIMIT_W-1:0]      heap_limit_reg;
    logic [scba_pkg::MAX_REQ_W-1:0]         max_request_reg;

    logic                                   ram_we;
    logic [AW-1:0]                          ram_waddr;
    scba_pkg::hdr_t                         ram_wdata;
    logic [AW-1:0]                          ram_raddr;
    scba_pkg::hdr_t                         ram_rdata;

    logic                                   hdr_neg;
    scba_pkg::hdr_t                         hdr_mag;
    scba_pkg::hdr_t                         size_ext;
    logic                                   hit;
    logic [FW-1:0]                          walk_step;
    logic                                   walk_active;
    logic [LW-1:0]                          lim;
    logic [LW-1:0]                          bump_lw;
    logic                                   bump_ok;
    logic [scba_pkg::ADDRESS_W-1:0]         addr_dec;
    logic                                   free_ok;
    scba_pkg::avail_t                       size_id;

    scba_ram #(
        .WIDTH (scba_pkg::HDR_W),
        .DEPTH (HEAP_BYTES)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // header decode and fit check
    assign hdr_neg   = ram_rdata[scba_pkg::HDR_W-1];
    assign hdr_mag   = hdr_neg ? scba_pkg::hdr_t'(8'd0 - ram_rdata) : ram_rdata;
    assign size_ext  = {1'b0, size_reg};
    assign size_id   = scba_pkg::class_of(size_ext);
    assign hit       = (size_reg <= 7'd8) ? (hdr_mag == size_ext)
                     : ((size_ext <= hdr_mag) &&
                        ((size_ext + {2'b00, size_reg[6:1]}) >= hdr_mag));
    assign walk_step   = walk_reg + FW'(hdr_mag) + FW'(1);
    assign walk_active = walk_reg < FW'(bump_reg);

    // bump room check
    assign lim     = (LW'(heap_limit_reg) < HEAP_LW) ? LW'(heap_limit_reg) : HEAP_LW;
    assign bump_lw = LW'(bump_reg);
    assign bump_ok = (lim > bump_lw) && ((lim - bump_lw) > (LW'(size_reg) + LW'(1)));

    assign addr_dec = addr_reg - 10'd1;
    assign free_ok  = (req.address != '0) && (FW'(req.address) < FW'(bump_reg));

    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        bump_next   = bump_reg;
        counts_next = counts_reg;
        walk_next   = walk_reg;
        clr_next    = clr_reg;
        type_next   = type_reg;
        size_next   = size_reg;
        addr_next   = addr_reg;
        status_next = status_reg;
        where_next  = where_reg;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_raddr   = '0;
        out_load    = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                if (clr_reg == LAST_ROW)
                    state_next = ST_IDLE;
                else
                    clr_next = clr_reg + AW'(1);
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    type_next   = req.req_type;
                    size_next   = req.req_size;
                    addr_next   = req.address;
                    status_next = scba_pkg::STATUS_OK;
                    where_next  = '0;
                    walk_next   = '0;
                    case (req.req_type)
                        scba_pkg::REQ_ALLOC:
                        begin
                            if (req.req_size == '0 ||
                                {1'b0, req.req_size} >= max_request_reg)
                            begin
                                status_next = scba_pkg::STATUS_NOSPACE;
                                state_next  = ST_RESULT;
                            end
                            else if ((scba_pkg::class_of({1'b0, req.req_size}) & counts_reg)
                                     != '0)
                                state_next = ST_WALK_RD;
                            else
                                state_next = ST_BUMP;
                        end
                        scba_pkg::REQ_FREE:
                        begin
                            if (free_ok)
                                state_next = ST_FREE_RD;
                            else
                            begin
                                status_next = scba_pkg::STATUS_BADFREE;
                                state_next  = ST_RESULT;
                            end
                        end
                        scba_pkg::REQ_RECOUNT:
                        begin
                            if ((counts_reg & scba_pkg::AV_RECOUNT) != '0)
                            begin
                                counts_next = '0;
                                state_next  = ST_WALK_RD;
                            end
                            else
                                state_next = ST_RESULT;
                        end
                        default:
                        begin
                            status_next = scba_pkg::STATUS_NOSPACE;
                            state_next  = ST_RESULT;
                        end
                    endcase
                end
            end

            ST_WALK_RD:
            begin
                ram_raddr = AW'(walk_reg);
                if (walk_active)
                    state_next = ST_WALK_CHK;
                else if (type_reg == scba_pkg::REQ_ALLOC)
                    state_next = ST_BUMP;
                else
                    state_next = ST_RESULT;
            end

            ST_WALK_CHK:
            begin
                walk_next  = walk_step;
                state_next = ST_WALK_RD;
                if (hdr_neg)
                begin
                    if (type_reg == scba_pkg::REQ_ALLOC)
                    begin
                        if (hit)
                        begin
                            ram_we      = 1'b1;
                            ram_waddr   = AW'(walk_reg);
                            ram_wdata   = hdr_mag;
                            counts_next = counts_reg - (size_id & scba_pkg::AV_ONES);
                            where_next  = scba_pkg::ADDRESS_W'(walk_reg + FW'(1));
                            state_next  = ST_RESULT;
                        end
                    end
                    else
                        counts_next = scba_pkg::count_freed(counts_reg, hdr_mag);
                end
            end

            ST_BUMP:
            begin
                if (bump_ok)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = bump_reg;
                    ram_wdata  = size_ext;
                    where_next = scba_pkg::ADDRESS_W'(FW'(bump_reg) + FW'(1));
                    bump_next  = AW'(FW'(bump_reg) + FW'(size_reg) + FW'(1));
                end
                else
                    status_next = scba_pkg::STATUS_NOSPACE;
                state_next = ST_RESULT;
            end

            ST_FREE_RD:
            begin
                ram_raddr  = AW'(addr_dec);
                state_next = ST_FREE_CHK;
            end

            ST_FREE_CHK:
            begin
                if (!hdr_neg && ram_rdata != '0)
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = AW'(addr_dec);
                    ram_wdata   = scba_pkg::hdr_t'(8'd0 - ram_rdata);
                    counts_next = scba_pkg::count_freed(counts_reg, ram_rdata);
                end
                else
                    status_next = scba_pkg::STATUS_BADFREE;
                state_next = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            bump_reg        <= '0;
            counts_reg      <= '0;
            clr_reg         <= '0;
            out_valid_reg   <= 1'b0;
            heap_limit_reg  <= scba_pkg::HEAP_LIMIT_RST;
            max_request_reg <= scba_pkg::MAX_REQUEST_RST;
        end
        else
        begin
            state_reg  <= state_next;
            bump_reg   <= bump_next;
            counts_reg <= counts_next;
            clr_reg    <= clr_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    scba_pkg::CFG_HEAP_LIMIT:  heap_limit_reg  <= cfg_data;
                    scba_pkg::CFG_MAX_REQUEST: max_request_reg <= cfg_data[scba_pkg::MAX_REQ_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        walk_reg   <= walk_next;
        type_reg   <= type_next;
        size_reg   <= size_next;
        addr_reg   <= addr_next;
        status_reg <= status_next;
        where_reg  <= where_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_where_reg  <= where_reg;
            out_avail_reg  <= counts_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.alloc_address = out_where_reg;
    assign rsp.avail_word    = out_avail_reg;

endmodule

// File: sv/scba_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module scba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: verif/size_class_block_allocator_test.sv
// self-checking testbench for the size class block allocator: directed and random requests
`timescale 1ns / 1ps

module size_class_block_allocator_test;

    localparam int HEAP_SIZE = 1024;
    localparam logic [scba_pkg::REQ_TYPE_W-1:0] REQ_RESERVED = 2'd3;

    typedef struct packed {
        logic [scba_pkg::STATUS_W-1:0]  status;
        logic [scba_pkg::ADDRESS_W-1:0] alloc_address;
        scba_pkg::avail_t               avail_word;
    } alloc_result_t;

    class alloc_scoreboard;
        byte              hdr_bytes [HEAP_SIZE];
        int unsigned      bump;
        scba_pkg::avail_t counts;
        int unsigned      limit_reg;
        int unsigned      max_req_reg;
        alloc_result_t    queued_results [$];
        int unsigned      live_blocks [$];
        int unsigned      freed_sizes [$];
        int unsigned      mismatches;
        int unsigned      results_seen;
        int unsigned      requests;
        int unsigned      grants;
        int unsigned      reuses;
        int unsigned      frees_ok;
        int unsigned      recounts;
        int unsigned      saturations;

        function new();
            foreach (hdr_bytes[i])
                hdr_bytes[i] = 0;
            bump         = 0;
            counts       = '0;
            limit_reg    = scba_pkg::HEAP_LIMIT_RST;
            max_req_reg  = scba_pkg::MAX_REQUEST_RST;
            mismatches   = 0;
            results_seen = 0;
            requests     = 0;
            grants       = 0;
            reuses       = 0;
            frees_ok     = 0;
            recounts     = 0;
            saturations  = 0;
        endfunction

        function int unsigned block_bytes(byte h);
            int v;
            v = h;
            return (v < 0) ? -v : v;
        endfunction

        function scba_pkg::avail_t class_mask(int unsigned sz);
            case (sz)
                0:       return '0;
                1:       return scba_pkg::AV_EQ1;
                2:       return scba_pkg::AV_EQ2;
                4:       return scba_pkg::AV_EQ4;
                8:       return scba_pkg::AV_EQ8;
                default: return (sz < 8) ? scba_pkg::AV_ODD : scba_pkg::AV_GT8;
            endcase
        endfunction

        function void tally_free(int unsigned sz);
            scba_pkg::avail_t id;
            scba_pkg::avail_t bumped;
            id     = class_mask(sz);
            bumped = counts + (id & scba_pkg::AV_ONES);
            if ((counts & id) != '0 && (bumped & id) == '0)
            begin
                counts = counts | scba_pkg::AV_RECOUNT;
                saturations++;
            end
            else
                counts = bumped;
        endfunction

        function int unsigned reuse_free_block(int unsigned sz);
            scba_pkg::avail_t id;
            int unsigned      pos;
            int unsigned      m;
            bit               fits;
            id  = class_mask(sz);
            pos = 0;
            if ((id & counts) == '0)
                return 0;
            while (pos < bump && pos < HEAP_SIZE)
            begin
                m = block_bytes(hdr_bytes[pos]);
                if (hdr_bytes[pos] < 0)
                begin
                    if (sz <= 8)
                        fits = (m == sz);
                    else
                        fits = (sz <= m) && (sz + sz / 2 >= m);
                    if (fits)
                    begin
                        counts         = counts - (id & scba_pkg::AV_ONES);
                        hdr_bytes[pos] = byte'(m);
                        return pos + 1;
                    end
                end
                pos += m + 1;
            end
            return 0;
        endfunction

        function void write_register(logic [scba_pkg::CFG_INDEX_W-1:0] idx,
                                     logic [scba_pkg::CFG_DATA_W-1:0] data);
            if (idx == scba_pkg::CFG_HEAP_LIMIT)
                limit_reg = data & 11'h7FF;
            else
                max_req_reg = data & 11'h0FF;
        endfunction

        function alloc_result_t note_request(logic [scba_pkg::REQ_TYPE_W-1:0] kind,
                                             int unsigned sz, int unsigned addr);
            alloc_result_t r;
            int unsigned   where;
            int unsigned   lim;
            int unsigned   m;
            int unsigned   pos;
            r.status = scba_pkg::STATUS_OK;
            where    = 0;
            requests++;
            case (kind)
                scba_pkg::REQ_ALLOC:
                begin
                    if (sz == 0 || sz >= max_req_reg)
                        r.status = scba_pkg::STATUS_NOSPACE;
                    else
                    begin
                        where = reuse_free_block(sz);
                        if (where != 0)
                            reuses++;
                        else
                        begin
                            lim = (limit_reg < HEAP_SIZE) ? limit_reg : HEAP_SIZE;
                            if (lim > bump && lim - bump > sz + 1)
                            begin
                                hdr_bytes[bump] = byte'(sz);
                                where = bump + 1;
                                bump  = bump + sz + 1;
                            end
                            else
                                r.status = scba_pkg::STATUS_NOSPACE;
                        end
                        if (where != 0)
                        begin
                            grants++;
                            live_blocks.push_back(where);
                        end
                    end
                end
                scba_pkg::REQ_FREE:
                begin
                    if (addr > 0 && addr < bump && hdr_bytes[addr-1] > 0)
                    begin
                        m = block_bytes(hdr_bytes[addr-1]);
                        hdr_bytes[addr-1] = byte'(-int'(m));
                        tally_free(m);
                        frees_ok++;
                        foreach (live_blocks[i])
                            if (live_blocks[i] == addr)
                            begin
                                live_blocks.delete(i);
                                break;
                            end
                        freed_sizes.push_back(m);
                        if (freed_sizes.size() > 16)
                            void'(freed_sizes.pop_front());
                    end
                    else
                        r.status = scba_pkg::STATUS_BADFREE;
                end
                scba_pkg::REQ_RECOUNT:
                begin
                    recounts++;
                    if ((counts & scba_pkg::AV_RECOUNT) != '0)
                    begin
                        counts = '0;
                        pos    = 0;
                        while (pos < bump && pos < HEAP_SIZE)
                        begin
                            m = block_bytes(hdr_bytes[pos]);
                            if (hdr_bytes[pos] < 0)
                                tally_free(m);
                            pos += m + 1;
                        end
                    end
                end
                default:
                    r.status = scba_pkg::STATUS_NOSPACE;
            endcase
            r.alloc_address = where[scba_pkg::ADDRESS_W-1:0];
            r.avail_word    = counts;
            queued_results.push_back(r);
            return r;
        endfunction

        function void check_response(logic [scba_pkg::STATUS_W-1:0] status,
                                     logic [scba_pkg::ADDRESS_W-1:0] alloc_address,
                                     scba_pkg::avail_t avail_word);
            alloc_result_t want;
            results_seen++;
            if (queued_results.size() == 0)
            begin
                $error("unexpected result word: status %0d alloc_address %0d avail_word %h",
                       status, alloc_address, avail_word);
                mismatches++;
                return;
            end
            want = queued_results.pop_front();
            if (status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, status);
                mismatches++;
            end
            if (alloc_address !== want.alloc_address)
            begin
                $error("alloc_address: expected %0d, actual %0d", want.alloc_address,
                       alloc_address);
                mismatches++;
            end
            if (avail_word !== want.avail_word)
            begin
                $error("avail_word: expected %h, actual %h", want.avail_word, avail_word);
                mismatches++;
            end
        endfunction

        function int pending();
            return queued_results.size();
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_wr_en;
    logic [scba_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [scba_pkg::CFG_DATA_W-1:0]  cfg_data;

    scba_req_if req_ch ();
    scba_rsp_if rsp_ch ();

    alloc_scoreboard sb;
    int unsigned     hold_asks;
    int unsigned     hold_served;
    int unsigned     hold_left;
    int unsigned     rx_mode;
    int unsigned     rx_count;
    int unsigned     burst_left;
    int unsigned     settings_used;

    size_class_block_allocator #(
        .HEAP_BYTES(HEAP_SIZE)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // response side: random stall modes plus an occasional long hold
    initial
    begin
        rsp_ch.ready = 1'b0;
        hold_left    = 0;
        hold_served  = 0;
        rx_mode      = 0;
        rx_count     = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_asks)
            begin
                hold_left   = 200;
                hold_served = hold_asks;
            end
            if (rx_count % 64 == 0)
                rx_mode = $urandom_range(0, 3);
            rx_count++;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready = 1'b0;
            end
            else
                case (rx_mode)
                    0:       rsp_ch.ready = 1'b1;
                    1:       rsp_ch.ready = ($urandom_range(0, 9) < 7);
                    2:       rsp_ch.ready = (rx_count % 4 != 0);
                    default: rsp_ch.ready = ($urandom_range(0, 9) < 3);
                endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready)
            sb.check_response(rsp_ch.status, rsp_ch.alloc_address, rsp_ch.avail_word);
    end

    task automatic push_word(input logic [scba_pkg::REQ_TYPE_W-1:0] kind,
                             input int unsigned sz, input int unsigned addr,
                             output alloc_result_t predicted);
        req_ch.valid    = 1'b1;
        req_ch.req_type = kind;
        req_ch.req_size = sz[scba_pkg::REQ_SIZE_W-1:0];
        req_ch.address  = addr[scba_pkg::ADDRESS_W-1:0];
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        predicted = sb.note_request(kind, sz, addr);
        @(negedge clk);
    endtask

    task automatic drain();
        req_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_cfg(input logic [scba_pkg::CFG_INDEX_W-1:0] idx,
                             input int unsigned value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = value[scba_pkg::CFG_DATA_W-1:0];
        sb.write_register(idx, value[scba_pkg::CFG_DATA_W-1:0]);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic directed_requests();
        alloc_result_t o;
        int unsigned   big;
        int unsigned   eights [4];
        int unsigned   smalls [4];
        int unsigned   small_sizes [4];
        small_sizes = '{1, 2, 4, 5};
        push_word(scba_pkg::REQ_RECOUNT, 0, 0, o);
        push_word(scba_pkg::REQ_ALLOC, 0, 0, o);
        push_word(scba_pkg::REQ_ALLOC, 127, 0, o);
        big = o.alloc_address;
        push_word(scba_pkg::REQ_FREE, 0, big + 1, o);
        push_word(scba_pkg::REQ_FREE, 0, 0, o);
        push_word(scba_pkg::REQ_FREE, 0, 1023, o);
        push_word(scba_pkg::REQ_FREE, 0, big, o);
        push_word(scba_pkg::REQ_FREE, 0, big, o);
        push_word(scba_pkg::REQ_ALLOC, 100, 0, o);
        for (int i = 0; i < 4; i++)
        begin
            push_word(scba_pkg::REQ_ALLOC, 8, 0, o);
            eights[i] = o.alloc_address;
        end
        for (int i = 0; i < 4; i++)
            push_word(scba_pkg::REQ_FREE, 0, eights[i], o);
        push_word(scba_pkg::REQ_RECOUNT, 0, 0, o);
        push_word(scba_pkg::REQ_ALLOC, 8, 0, o);
        push_word(REQ_RESERVED, 127, 1023, o);
        for (int i = 0; i < 4; i++)
        begin
            push_word(scba_pkg::REQ_ALLOC, small_sizes[i], 0, o);
            smalls[i] = o.alloc_address;
        end
        for (int i = 0; i < 4; i++)
            push_word(scba_pkg::REQ_FREE, 0, smalls[i], o);
        push_word(scba_pkg::REQ_ALLOC, 3, 0, o);
    endtask

    function automatic int unsigned pick_size();
        int unsigned p;
        int          near;
        p = $urandom_range(0, 99);
        if (p < 40)
            return $urandom_range(1, 8);
        if (p < 65)
            return $urandom_range(9, 24);
        if (p < 78 && sb.freed_sizes.size() > 0)
            return sb.freed_sizes[$urandom_range(0, sb.freed_sizes.size() - 1)];
        if (p < 90)
            return $urandom_range(0, 127);
        near = int'(sb.max_req_reg) - 1 + int'($urandom_range(0, 1));
        if (near < 0)
            near = 0;
        if (near > 127)
            near = 127;
        return near;
    endfunction

    function automatic int unsigned pick_free_address();
        int unsigned p;
        int unsigned n;
        p = $urandom_range(0, 99);
        n = sb.live_blocks.size();
        if (p < 75 && n > 0)
            return sb.live_blocks[$urandom_range(0, n - 1)];
        if (p < 85)
            return $urandom_range(0, 1023);
        if (p < 93 && n > 0)
            return sb.live_blocks[$urandom_range(0, n - 1)] + 1;
        return $urandom_range(0, sb.bump);
    endfunction

    task automatic random_request();
        alloc_result_t o;
        int unsigned   p;
        p = $urandom_range(0, 99);
        if (p < 50)
            push_word(scba_pkg::REQ_ALLOC, pick_size(), $urandom_range(0, 1023), o);
        else if (p < 85)
            push_word(scba_pkg::REQ_FREE, $urandom_range(0, 127), pick_free_address(), o);
        else if (p < 95)
            push_word(scba_pkg::REQ_RECOUNT, $urandom_range(0, 127), $urandom_range(0, 1023),
                      o);
        else
            push_word(REQ_RESERVED, $urandom_range(0, 127), $urandom_range(0, 1023), o);
        if (burst_left == 0)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 8))
                @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 12);
        end
        else
            burst_left--;
    endtask

    task automatic run_phase(input int unsigned limit, input int unsigned max_req,
                             input int unsigned n_items, input bit long_hold,
                             input bit mid_pause);
        drain();
        repeat (4)
            @(negedge clk);
        write_cfg(scba_pkg::CFG_HEAP_LIMIT, limit);
        write_cfg(scba_pkg::CFG_MAX_REQUEST, max_req);
        settings_used++;
        for (int unsigned i = 0; i < n_items; i++)
        begin
            if (long_hold && i == 5)
                hold_asks++;
            if (mid_pause && i == n_items / 2)
                drain();
            random_request();
        end
    endtask

    initial
    begin
        sb              = new();
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = scba_pkg::CFG_HEAP_LIMIT;
        cfg_data        = '0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = scba_pkg::REQ_ALLOC;
        req_ch.req_size = '0;
        req_ch.address  = '0;
        hold_asks       = 0;
        burst_left      = 0;
        settings_used   = 1;
        repeat (9)
            @(negedge clk);
        rst_n = 1'b1;

        directed_requests();
        run_phase(150, 128, 80, 1'b0, 1'b0);
        run_phase(400, 16, 120, 1'b1, 1'b0);
        run_phase(2047, 255, 150, 1'b0, 1'b1);
        run_phase(100, 128, 50, 1'b0, 1'b0);
        run_phase(2, 1, 20, 1'b0, 1'b0);
        run_phase(1024, 9, 100, 1'b1, 1'b0);
        run_phase(700, 128, 130, 1'b0, 1'b1);
        run_phase(1024, 128, 100, 1'b0, 1'b0);

        drain();
        repeat (20)
            @(negedge clk);

        $display("covered %0d requests under %0d register settings: %0d grants (%0d reused),",
                 sb.requests, settings_used, sb.grants, sb.reuses);
        $display("%0d frees, %0d recounts, %0d saturating frees; %0d results, %0d mismatches",
                 sb.frees_ok, sb.recounts, sb.saturations, sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
sv/scba_pkg.sv
sv/scba_ifs.sv
sv/scba_ram.sv
sv/size_class_block_allocator.sv
verif/size_class_block_allocator_test.sv
